/* rtl/nsr_pkg.sv */
// Shared types, constants and microprogram for the Newton square-root block.
// Used by nsr_seq, nsr_dp and newton_square_root_top. No dependencies.
`default_nettype none

package nsr_pkg;

	localparam int WORD_W    = 64;
	localparam int HALF_W    = WORD_W / 2;
	localparam int ACC_W     = 2 * WORD_W;
	localparam int FRAC_BITS = 32;
	localparam int DVD_W     = WORD_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DVD_W);
	localparam int TOL_W     = 32;
	localparam int STEP_W    = 10;
	localparam int UPC_W     = 4;

	localparam logic [STEP_W-1:0] LIMIT_RESET = STEP_W'(1000);

	typedef enum logic [1:0] {
		ST_CONV  = 2'd0,
		ST_LIMIT = 2'd1,
		ST_ZERR  = 2'd2
	} status_t;

	typedef enum logic {
		REG_TOLERANCE  = 1'b0,
		REG_ITER_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_ZERR,
		DP_DIFF,
		DP_DIV,
		DP_UPD,
		DP_TEST,
		DP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_SET,
		ACC_ADD_MID,
		ACC_ADD_HI
	} acc_op_t;

	// partial products of x*x: lo*lo, lo*hi, hi*lo, hi*hi
	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL,
		MS_HH
	} mul_sel_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT,
		J_BRANCH,
		J_GOTO
	} jmp_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_FIRE,
		C_X_ZERO,
		C_DIV_MORE,
		C_NOT_DONE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		dp_op_t           dp_op;
		acc_op_t          acc_op;
		mul_sel_t         mul_sel;
		jmp_t             jmp;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic x_zero;
		logic div_more;
		logic not_done;
		logic out_free;
	} flags_t;

	// program labels
	localparam logic [UPC_W-1:0] PC_WAIT = UPC_W'(0);
	localparam logic [UPC_W-1:0] PC_CHK  = UPC_W'(1);
	localparam logic [UPC_W-1:0] PC_MUL0 = UPC_W'(2);
	localparam logic [UPC_W-1:0] PC_MUL1 = UPC_W'(3);
	localparam logic [UPC_W-1:0] PC_MUL2 = UPC_W'(4);
	localparam logic [UPC_W-1:0] PC_MUL3 = UPC_W'(5);
	localparam logic [UPC_W-1:0] PC_ACC  = UPC_W'(6);
	localparam logic [UPC_W-1:0] PC_DIFF = UPC_W'(7);
	localparam logic [UPC_W-1:0] PC_DIV  = UPC_W'(8);
	localparam logic [UPC_W-1:0] PC_UPD  = UPC_W'(9);
	localparam logic [UPC_W-1:0] PC_TEST = UPC_W'(10);
	localparam logic [UPC_W-1:0] PC_OUT  = UPC_W'(11);

	function automatic ctrl_t mk(dp_op_t op, acc_op_t ac, mul_sel_t ms, jmp_t j, cond_t c,
		logic [UPC_W-1:0] tgt);
		ctrl_t w;
		w.dp_op   = op;
		w.acc_op  = ac;
		w.mul_sel = ms;
		w.jmp     = j;
		w.cond    = c;
		w.target  = tgt;
		return w;
	endfunction

	// microprogram ROM
	function automatic ctrl_t prog_word(logic [UPC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			PC_WAIT: w = mk(DP_LOAD, ACC_HOLD,    MS_LL, J_WAIT,   C_IN_FIRE,  PC_CHK);
			PC_CHK:  w = mk(DP_ZERR, ACC_HOLD,    MS_LL, J_BRANCH, C_X_ZERO,   PC_OUT);
			PC_MUL0: w = mk(DP_NONE, ACC_HOLD,    MS_LL, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_MUL1: w = mk(DP_NONE, ACC_SET,     MS_LH, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_MUL2: w = mk(DP_NONE, ACC_ADD_MID, MS_HL, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_MUL3: w = mk(DP_NONE, ACC_ADD_MID, MS_HH, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_ACC:  w = mk(DP_NONE, ACC_ADD_HI,  MS_LL, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_DIFF: w = mk(DP_DIFF, ACC_HOLD,    MS_LL, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_DIV:  w = mk(DP_DIV,  ACC_HOLD,    MS_LL, J_BRANCH, C_DIV_MORE, PC_DIV);
			PC_UPD:  w = mk(DP_UPD,  ACC_HOLD,    MS_LL, J_NEXT,   C_ALWAYS,   PC_WAIT);
			PC_TEST: w = mk(DP_TEST, ACC_HOLD,    MS_LL, J_BRANCH, C_NOT_DONE, PC_MUL0);
			PC_OUT:  w = mk(DP_OUT,  ACC_HOLD,    MS_LL, J_WAIT,   C_OUT_FREE, PC_WAIT);
			default: w = mk(DP_NONE, ACC_HOLD,    MS_LL, J_GOTO,   C_ALWAYS,   PC_WAIT);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/nsr_seq.sv */
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on nsr_pkg.
`default_nettype none

module nsr_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nsr_pkg::flags_t flags,
	output nsr_pkg::ctrl_t       ctrl,
	output logic                 go
);
	import nsr_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;

	assign ctrl = prog_word(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:   go = 1'b1;
			C_IN_FIRE:  go = flags.in_fire;
			C_X_ZERO:   go = flags.x_zero;
			C_DIV_MORE: go = flags.div_more;
			C_NOT_DONE: go = flags.not_done;
			C_OUT_FREE: go = flags.out_free;
			default:    go = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctrl.jmp)
			J_NEXT:   upc_nxt = upc_q + UPC_W'(1);
			J_WAIT:   upc_nxt = go ? ctrl.target : upc_q;
			J_BRANCH: upc_nxt = go ? ctrl.target : upc_q + UPC_W'(1);
			J_GOTO:   upc_nxt = ctrl.target;
			default:  upc_nxt = PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_WAIT;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/nsr_dp.sv */
// Datapath: config registers, 32x32 multiplier with 128-bit accumulator,
// radix-2 restoring divider, Newton update and output register. Depends on nsr_pkg.
`default_nettype none

module nsr_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire nsr_pkg::ctrl_t                ctrl,
	input  wire logic                          go,
	output nsr_pkg::flags_t                    flags,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [nsr_pkg::TOL_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [nsr_pkg::WORD_W-1:0]    radicand,
	input  wire logic [nsr_pkg::WORD_W-1:0]    start_guess,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [nsr_pkg::WORD_W-1:0]         root,
	output logic [nsr_pkg::STEP_W-1:0]         steps_used,
	output logic [1:0]                         status
);
	import nsr_pkg::*;

	logic [TOL_W-1:0]  tol_q;
	logic [STEP_W-1:0] limit_q;

	logic [WORD_W-1:0] a_q, x_q, prod_q, rem_q, delta_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [WORD_W:0]   quo_q;
	logic              sticky_q, down_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] steps_q;
	status_t           status_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] root_q;
	logic [STEP_W-1:0] steps_out_q;
	status_t           status_out_q;

	logic [HALF_W-1:0] opa, opb;
	logic [WORD_W-1:0] prod;
	logic [ACC_W-1:0]  acc_shr;
	logic [WORD_W-1:0] sq, d;
	logic              ge_a;
	logic [WORD_W:0]   trial, trial_sub;
	logic              ge_x;
	logic [WORD_W-1:0] qv;
	logic [WORD_W:0]   up_sum;
	logic [WORD_W-1:0] nx, delta;
	logic [STEP_W-1:0] lim_eff;
	logic              hit_tol, hit_lim, x_zero;
	logic              in_fire, out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (ctrl.dp_op == DP_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign root       = root_q;
	assign steps_used = steps_out_q;
	assign status     = status_out_q;

	// partial product select
	always_comb begin
		case (ctrl.mul_sel)
			MS_LL:   begin opa = x_q[HALF_W-1:0];      opb = x_q[HALF_W-1:0];      end
			MS_LH:   begin opa = x_q[HALF_W-1:0];      opb = x_q[WORD_W-1:HALF_W]; end
			MS_HL:   begin opa = x_q[WORD_W-1:HALF_W]; opb = x_q[HALF_W-1:0];      end
			default: begin opa = x_q[WORD_W-1:HALF_W]; opb = x_q[WORD_W-1:HALF_W]; end
		endcase
	end
	assign prod = WORD_W'(opa) * WORD_W'(opb);

	// scaled square, saturated, and its distance from the radicand
	assign acc_shr = acc_q >> FRAC_BITS;
	assign sq      = (|acc_shr[ACC_W-1:WORD_W]) ? '1 : acc_shr[WORD_W-1:0];
	assign ge_a    = (sq >= a_q);
	assign d       = ge_a ? (sq - a_q) : (a_q - sq);

	// one divider step
	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign ge_x      = (trial >= {1'b0, x_q});
	assign trial_sub = trial - {1'b0, x_q};

	// quotient halved; anything above the kept window saturates
	assign qv     = sticky_q ? '1 : quo_q[WORD_W:1];
	assign up_sum = {1'b0, x_q} + {1'b0, qv};
	always_comb begin
		if (down_q) begin
			nx    = (qv >= x_q) ? '0 : (x_q - qv);
			delta = (qv >= x_q) ? x_q : qv;
		end else begin
			nx    = up_sum[WORD_W] ? '1 : up_sum[WORD_W-1:0];
			delta = up_sum[WORD_W] ? ~x_q : qv;
		end
	end

	assign lim_eff = (limit_q == '0) ? STEP_W'(1) : limit_q;
	assign hit_tol = (delta_q <= WORD_W'(tol_q));
	assign hit_lim = (steps_q >= lim_eff);
	assign x_zero  = (x_q == '0);

	// in_fire, x_zero, div_more, not_done, out_free
	assign flags = {in_fire, x_zero, (cnt_q != '0), !(hit_tol || hit_lim || x_zero), out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TOLERANCE:  tol_q   <= cfg_data;
				REG_ITER_LIMIT: limit_q <= cfg_data[STEP_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.dp_op == DP_OUT && go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;

		case (ctrl.acc_op)
			ACC_SET:     acc_q <= {{WORD_W{1'b0}}, prod_q};
			ACC_ADD_MID: acc_q <= acc_q + ({{WORD_W{1'b0}}, prod_q} << HALF_W);
			ACC_ADD_HI:  acc_q <= acc_q + ({{WORD_W{1'b0}}, prod_q} << WORD_W);
			default:     ;
		endcase

		case (ctrl.dp_op)
			DP_LOAD: begin
				if (go) begin
					a_q     <= radicand;
					x_q     <= start_guess;
					steps_q <= '0;
				end
			end
			DP_ZERR: status_q <= ST_ZERR;
			DP_DIFF: begin
				down_q   <= ge_a;
				dvd_q    <= {d, {FRAC_BITS{1'b0}}};
				rem_q    <= '0;
				quo_q    <= '0;
				sticky_q <= 1'b0;
				cnt_q    <= CNT_W'(DVD_W - 1);
			end
			DP_DIV: begin
				dvd_q    <= dvd_q << 1;
				rem_q    <= ge_x ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
				quo_q    <= {quo_q[WORD_W-1:0], ge_x};
				sticky_q <= sticky_q | quo_q[WORD_W];
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			DP_UPD: begin
				x_q     <= nx;
				delta_q <= delta;
				steps_q <= steps_q + STEP_W'(1);
			end
			DP_TEST: begin
				if (hit_tol)
					status_q <= ST_CONV;
				else if (hit_lim)
					status_q <= ST_LIMIT;
				else
					status_q <= ST_ZERR;
			end
			DP_OUT: begin
				if (go) begin
					root_q       <= x_q;
					steps_out_q  <= steps_q;
					status_out_q <= status_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/newton_square_root_top.sv */
// Each Newton step: partial products of x*x, accumulate, difference, radix-2 divide,
// update and test; a zero start guess goes straight to the output step. One word in
// flight; the next word can be taken the cycle after the result is parked in the
// output register, which happens only once that register is free. Async active-low
// reset: sequencer to its wait step, output empty, tolerance 0, iteration limit 1000.
`default_nettype none

module newton_square_root_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [nsr_pkg::TOL_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [nsr_pkg::WORD_W-1:0]    radicand,
	input  wire logic [nsr_pkg::WORD_W-1:0]    start_guess,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [nsr_pkg::WORD_W-1:0]         root,
	output logic [nsr_pkg::STEP_W-1:0]         steps_used,
	output logic [1:0]                         status
);
	import nsr_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;
	logic   go;

	nsr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.go     (go)
	);

	nsr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.go          (go),
		.flags       (flags),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.radicand    (radicand),
		.start_guess (start_guess),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.root        (root),
		.steps_used  (steps_used),
		.status      (status)
	);

endmodule

`default_nettype wire

/* tb/nsr_root_checker.sv */
// Result checker for newton_square_root_top: tracks register writes, predicts each
// root / step count / status on input acceptance and compares outputs in order.
// Depends on nsr_pkg for widths, status codes and register indexes.
`timescale 1ns / 100ps

module nsr_root_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [nsr_pkg::TOL_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic [nsr_pkg::WORD_W-1:0] radicand,
	input  wire logic [nsr_pkg::WORD_W-1:0] start_guess,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic [nsr_pkg::WORD_W-1:0] root,
	input  wire logic [nsr_pkg::STEP_W-1:0] steps_used,
	input  wire logic [1:0]                 status,
	output int                              mismatches,
	output int                              outstanding,
	output int                              n_conv,
	output int                              n_limit,
	output int                              n_zerr
);
	import nsr_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] root;
		logic [STEP_W-1:0] steps;
		status_t           status;
	} root_result_t;

	root_result_t      pending_roots[$];
	root_result_t      want;
	logic [TOL_W-1:0]  tol_shadow;
	logic [STEP_W-1:0] lim_shadow;
	int                err_total;

	// Newton iteration on x*x - a, Q32.32, with the block's saturation rules
	function automatic root_result_t newton_root(logic [WORD_W-1:0] a, logic [WORD_W-1:0] x0,
		logic [TOL_W-1:0] tol, logic [STEP_W-1:0] lim_reg);
		logic [ACC_W-1:0]  prod;
		logic [ACC_W-1:0]  quo;
		logic [WORD_W-1:0] x, sq, d, q, nx, delta;
		logic [STEP_W:0]   lim;
		logic [STEP_W:0]   steps;
		logic              down;
		logic              done;
		root_result_t      r;
		r.root   = '0;
		r.steps  = '0;
		r.status = ST_ZERR;
		if (x0 == '0)
			return r;
		lim   = (lim_reg == '0) ? (STEP_W + 1)'(1) : {1'b0, lim_reg};
		x     = x0;
		steps = '0;
		done  = 1'b0;
		while (!done) begin
			prod = (ACC_W'(x) * ACC_W'(x)) >> FRAC_BITS;
			sq   = (prod[ACC_W-1:WORD_W] != '0) ? '1 : prod[WORD_W-1:0];
			down = sq >= a;
			d    = down ? sq - a : a - sq;
			quo  = ((ACC_W'(d) << FRAC_BITS) / ACC_W'(x)) >> 1;
			q    = (quo[ACC_W-1:WORD_W] != '0) ? '1 : quo[WORD_W-1:0];
			if (down)
				nx = (q >= x) ? '0 : x - q;
			else
				nx = (~x < q) ? '1 : x + q;
			delta = down ? x - nx : nx - x;
			x     = nx;
			steps = steps + 1'b1;
			if (delta <= WORD_W'(tol)) begin
				r.status = ST_CONV;
				done     = 1'b1;
			end else if (steps >= lim) begin
				r.status = ST_LIMIT;
				done     = 1'b1;
			end else if (x == '0) begin
				r.status = ST_ZERR;
				done     = 1'b1;
			end
		end
		r.root  = (r.status == ST_ZERR) ? '0 : x;
		r.steps = steps[STEP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_shadow = '0;
			lim_shadow = LIMIT_RESET;
			err_total  = 0;
			pending_roots.delete();
			mismatches  <= 0;
			outstanding <= 0;
			n_conv      <= 0;
			n_limit     <= 0;
			n_zerr      <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TOLERANCE)
					tol_shadow = cfg_data;
				else
					lim_shadow = cfg_data[STEP_W-1:0];
			end
			if (in_valid && in_ready)
				pending_roots.push_back(newton_root(radicand, start_guess, tol_shadow, lim_shadow));
			if (out_valid && out_ready) begin
				if (pending_roots.size() == 0) begin
					$error("unexpected result word: root %h steps %0d status %0d",
						root, steps_used, status);
					err_total++;
				end else begin
					want = pending_roots.pop_front();
					if (root !== want.root) begin
						$error("root: expected %h, got %h", want.root, root);
						err_total++;
					end
					if (steps_used !== want.steps) begin
						$error("steps_used: expected %0d, got %0d", want.steps, steps_used);
						err_total++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_total++;
					end
				end
				case (status)
					ST_CONV:  n_conv  <= n_conv + 1;
					ST_LIMIT: n_limit <= n_limit + 1;
					default:  n_zerr  <= n_zerr + 1;
				endcase
			end
			mismatches  <= err_total;
			outstanding <= pending_roots.size();
		end
	end

endmodule

/* tb/newton_square_root_top_tb.sv */
// Top-level testbench for newton_square_root_top: clock, reset, register writes,
// directed and random radicand/guess words, output backpressure and the verdict.
// Depends on nsr_pkg, newton_square_root_top and nsr_root_checker.
`timescale 1ns / 100ps

module newton_square_root_top_tb;
	import nsr_pkg::*;

	localparam int                WATCHDOG_LIMIT = 500000;
	localparam int                TAIL_CYCLES    = 120;
	localparam logic [WORD_W-1:0] FX_ONE         = 64'h0000_0001_0000_0000;
	localparam logic [WORD_W-1:0] ALL_ONES       = '1;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_valid   = 1'b0;
	logic              cfg_index   = 1'b0;
	logic [TOL_W-1:0]  cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic [WORD_W-1:0] radicand    = '0;
	logic [WORD_W-1:0] start_guess = '0;
	logic              out_ready   = 1'b0;
	logic              cfg_ready, in_ready, out_valid;
	logic [WORD_W-1:0] root;
	logic [STEP_W-1:0] steps_used;
	logic [1:0]        status;

	int mismatches, outstanding, n_conv, n_limit, n_zerr;
	int words_sent    = 0;
	int reg_writes    = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 86;
	int idle_cycles   = 0;

	newton_square_root_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.radicand   (radicand),
		.start_guess(start_guess),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root       (root),
		.steps_used (steps_used),
		.status     (status)
	);

	nsr_root_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.radicand   (radicand),
		.start_guess(start_guess),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root       (root),
		.steps_used (steps_used),
		.status     (status),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.n_conv     (n_conv),
		.n_limit    (n_limit),
		.n_zerr     (n_zerr)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// registers change only with nothing in flight
	task automatic write_reg(reg_idx_t idx, logic [TOL_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic set_regs(logic [TOL_W-1:0] tol, logic [TOL_W-1:0] lim);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_ITER_LIMIT, lim);
	endtask

	task automatic send_word(logic [WORD_W-1:0] a, logic [WORD_W-1:0] g);
		if (words_sent < 155) begin
			send_idle_pct = 34;
			recv_idle_pct = 86;
		end else if (words_sent < 310) begin
			send_idle_pct = 86;
			recv_idle_pct = 34;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		radicand    <= a;
		start_guess <= g;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	function automatic logic [WORD_W-1:0] rand_wide();
		return {$urandom, $urandom} >> $urandom_range(63);
	endfunction

	// mix: exact squares, zero guesses, wild guesses, guesses near the true root
	task automatic pick_word(output logic [WORD_W-1:0] a, output logic [WORD_W-1:0] g);
		int                roll;
		logic [WORD_W-1:0] j;
		real               rr, rt;
		roll = $urandom_range(99);
		case ($urandom_range(24))
			0:       a = '0;
			1:       a = ALL_ONES;
			default: a = rand_wide();
		endcase
		if (roll < 15) begin
			j = $urandom_range(65535, 1);
			a = (j * j) << FRAC_BITS;
			g = j << FRAC_BITS;
		end else if (roll < 18) begin
			g = '0;
		end else if (roll < 38) begin
			g = rand_wide();
		end else begin
			rr = real'(a[63:32]) * 4294967296.0 + real'(a[31:0]);
			rt = $sqrt(rr) * 65536.0 * (0.5 + real'($urandom_range(1500)) / 1000.0);
			g  = longint'(rt);
			if (g == '0)
				g = 64'd1;
		end
	endtask

	task automatic run_random(int count);
		logic [WORD_W-1:0] a, g;
		repeat (count) begin
			pick_word(a, g);
			send_word(a, g);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: tolerance 0, limit 1000; only words that settle at once
		send_word(4 * FX_ONE, 2 * FX_ONE);
		send_word(FX_ONE, FX_ONE);
		send_word('0, 64'd1);
		send_word(ALL_ONES, '0);

		// limit field written as 0 (upper data bits set, ignored): one step each, none for the zero guess
		set_regs(32'h0, 32'hFFFF_FC00);
		send_word('0, ALL_ONES);
		send_word(ALL_ONES, ALL_ONES);
		send_word(ALL_ONES, 64'd1);
		send_word(64'd1, 64'd1);
		send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_word('0, '0);
		send_word(ALL_ONES, FX_ONE);

		// widest tolerance, largest limit
		set_regs(32'hFFFF_FFFF, 32'h0000_03FF);
		send_word(ALL_ONES, 64'd1);
		send_word(64'd1, ALL_ONES);
		send_word(ALL_ONES, ALL_ONES);
		send_word('0, FX_ONE);
		send_word(2 * FX_ONE, FX_ONE);
		run_random(95);

		set_regs(32'h0, 32'd12);
		run_random(95);

		set_regs($urandom_range(65535, 1), $urandom_range(64, 16));
		run_random(95);

		set_regs($urandom, 32'd1);
		run_random(70);

		set_regs($urandom, $urandom_range(200, 2));
		run_random(95);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d radicand/guess words under %0d register writes (tolerance 0..max, limit 0..1023).",
			words_sent, reg_writes);
		$display("Results seen: %0d converged, %0d at limit, %0d zero guess.",
			n_conv, n_limit, n_zerr);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
